// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for concurrent assertions on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lbsa_pkg
// Constants and codes for the line bitmap SRAM allocator.
// ----------------------------------------------------------------------------
package lbsa_pkg;

    localparam int LINE_BYTES_DEF = 32;
    localparam int SRAM_BYTES_DEF = 8 * 1024;

    localparam logic [31:0] BASE_UNSET = 32'hFFFF_FFFF;

    typedef logic [1:0] mark_t;

    localparam mark_t MARK_FREE = 2'd0;
    localparam mark_t MARK_USED = 2'd1;
    localparam mark_t MARK_LAST = 2'd3;

    typedef logic [1:0] status_t;

    localparam status_t STAT_ALLOC_OK      = 2'd0;
    localparam status_t STAT_ALLOC_REFUSED = 2'd1;
    localparam status_t STAT_FREED         = 2'd2;
    localparam status_t STAT_FREE_IGNORED  = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

// ===== rtl/line_bitmap_sram_allocator_core.sv =====
// ----------------------------------------------------------------------------
// line_bitmap_sram_allocator_core
// First-fit line allocator: one 2-bit mark per SRAM line kept in a memory.
// ----------------------------------------------------------------------------
// One item is handled at a time. After reset the block sweeps the mark memory,
// one line per cycle, over all NUM_LINES lines (256 at the default sizes)
// before it takes its first item; configuration writes are taken throughout.
// An item is taken in an idle cycle. An allocate then checks the request,
// scans the lines (at most NUM_LINES of them), marks each line of the block
// and hands the result over. A free checks the request and, unless it starts
// at line 0, the mark of the line before it, walks the lines of the block,
// clears each of them and hands the result over. The single read port of the
// mark memory delivers one mark per cycle. The hand-over stalls while an
// earlier result still waits. A finished result is held in an output
// register, so the next item can be taken while the previous result still
// waits. LINE_BYTES must be a power of two; base_address may only be written
// while no item is in progress.
module line_bitmap_sram_allocator_core #(
    parameter int LINE_BYTES = lbsa_pkg::LINE_BYTES_DEF,
    parameter int SRAM_BYTES = lbsa_pkg::SRAM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_base_address,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_byte_count,
    input  logic [31:0] s_alignment,
    input  logic [31:0] s_block_address,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_address,
    output logic [1:0]  m_status
);

    localparam int NUM_LINES  = SRAM_BYTES / LINE_BYTES;
    localparam int LINE_SHIFT = $clog2(LINE_BYTES);
    localparam int IDX_W      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int CNT_W      = $clog2(NUM_LINES + 1);
    localparam int ARI_W      = CNT_W + 2;

    localparam logic [ARI_W-1:0] NUM_LINES_A = ARI_W'(NUM_LINES);
    localparam logic [32:0]      NUM_LINES_W = 33'(NUM_LINES);
    localparam logic [32:0]      LINE_MASK_W = 33'(LINE_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_LINES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_PREV,
        S_WALK,
        S_FILL,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    cand_reg, cand_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    phase_reg, phase_next;
    logic [CNT_W-1:0]    runlen_reg, runlen_next;
    logic [CNT_W-1:0]    need_reg, need_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic                fill_free_reg, fill_free_next;
    logic [31:0]         base_reg, base_next;
    logic                req_type_reg, req_type_next;
    logic [31:0]         byte_count_reg, byte_count_next;
    logic [31:0]         alignment_reg, alignment_next;
    logic [31:0]         block_address_reg, block_address_next;
    logic [31:0]         res_address_reg, res_address_next;
    lbsa_pkg::status_t   res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_address_reg, m_address_next;
    lbsa_pkg::status_t   m_status_reg, m_status_next;

    // Mark memory: one write port at idx_reg, one registered read port.
    lbsa_pkg::mark_t     mark_mem [NUM_LINES];
    lbsa_pkg::mark_t     mark_rdata_reg;
    logic                mem_we;
    lbsa_pkg::mark_t     mem_wdata;

    // Request checks.
    logic [32:0]         size_lines;
    logic [32:0]         align_lines;
    logic                alloc_ok;
    logic [31:0]         free_diff;
    logic [31:0]         free_start;
    logic                free_ok;

    // Scan arithmetic.
    logic [ARI_W-1:0]    jump_cand;
    logic                jump_fail;
    logic                run_done;
    logic [CNT_W-1:0]    phase_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_address = m_address_reg;
    assign m_status  = m_status_reg;

    always_comb begin
        size_lines  = ({1'b0, byte_count_reg} + LINE_MASK_W) >> LINE_SHIFT;
        align_lines = (alignment_reg == 32'd0) ? 33'd1
                    : (({1'b0, alignment_reg} + LINE_MASK_W) >> LINE_SHIFT);
        alloc_ok    = (base_reg != lbsa_pkg::BASE_UNSET) && (byte_count_reg != 32'd0)
                   && (size_lines <= NUM_LINES_W) && (align_lines <= NUM_LINES_W);

        free_diff   = block_address_reg - base_reg;
        free_start  = free_diff >> LINE_SHIFT;
        free_ok     = (block_address_reg != 32'd0)
                   && (block_address_reg[LINE_SHIFT-1:0] == '0)
                   && (block_address_reg >= base_reg)
                   && (free_start < 32'(NUM_LINES));

        // On a used line the next candidate is the first aligned start past it.
        jump_cand = ARI_W'(idx_reg) - ARI_W'(phase_reg) + ARI_W'(step_reg);
        jump_fail = (jump_cand + ARI_W'(need_reg)) > NUM_LINES_A;
        run_done  = (ARI_W'(runlen_reg) + ARI_W'(1)) == ARI_W'(need_reg);
        phase_inc = ((phase_reg + CNT_W'(1)) == step_reg) ? '0 : phase_reg + CNT_W'(1);
    end

    always_comb begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        cand_next          = cand_reg;
        start_next         = start_reg;
        hi_next            = hi_reg;
        phase_next         = phase_reg;
        runlen_next        = runlen_reg;
        need_next          = need_reg;
        step_next          = step_reg;
        fill_free_next     = fill_free_reg;
        base_next          = cfg_valid ? cfg_base_address : base_reg;
        req_type_next      = req_type_reg;
        byte_count_next    = byte_count_reg;
        alignment_next     = alignment_reg;
        block_address_next = block_address_reg;
        res_address_next   = res_address_reg;
        res_status_next    = res_status_reg;
        m_valid_next       = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_address_next     = m_address_reg;
        m_status_next      = m_status_reg;
        mem_we             = 1'b0;
        mem_wdata          = lbsa_pkg::MARK_FREE;

        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_type_next      = s_req_type;
                    byte_count_next    = s_byte_count;
                    alignment_next     = s_alignment;
                    block_address_next = s_block_address;
                    state_next         = S_CHECK;
                end
            end
            S_CHECK: begin
                res_address_next = '0;
                if (req_type_reg == lbsa_pkg::REQ_ALLOC) begin
                    if (!alloc_ok) begin
                        res_status_next = lbsa_pkg::STAT_ALLOC_REFUSED;
                        state_next      = S_DONE;
                    end else begin
                        need_next   = CNT_W'(size_lines);
                        step_next   = CNT_W'(align_lines);
                        cand_next   = '0;
                        idx_next    = '0;
                        phase_next  = '0;
                        runlen_next = '0;
                        state_next  = S_SCAN;
                    end
                end else begin
                    if (!free_ok) begin
                        res_status_next = lbsa_pkg::STAT_FREE_IGNORED;
                        state_next      = S_DONE;
                    end else begin
                        start_next = IDX_W'(free_start);
                        if (IDX_W'(free_start) != '0) begin
                            idx_next   = IDX_W'(free_start) - IDX_W'(1);
                            state_next = S_PREV;
                        end else begin
                            idx_next   = '0;
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (mark_rdata_reg == lbsa_pkg::MARK_FREE) begin
                    if (run_done) begin
                        hi_next          = idx_reg;
                        fill_free_next   = 1'b0;
                        res_address_next = base_reg + (32'(cand_reg) << LINE_SHIFT);
                        res_status_next  = lbsa_pkg::STAT_ALLOC_OK;
                        idx_next         = cand_reg;
                        state_next       = S_FILL;
                    end else begin
                        idx_next    = idx_reg + IDX_W'(1);
                        phase_next  = phase_inc;
                        runlen_next = runlen_reg + CNT_W'(1);
                    end
                end else if (jump_fail) begin
                    res_status_next = lbsa_pkg::STAT_ALLOC_REFUSED;
                    state_next      = S_DONE;
                end else begin
                    cand_next   = IDX_W'(jump_cand);
                    idx_next    = IDX_W'(jump_cand);
                    phase_next  = '0;
                    runlen_next = '0;
                end
            end
            S_PREV: begin
                // A used mark just before the start line means a mid-block address.
                if (mark_rdata_reg == lbsa_pkg::MARK_USED) begin
                    res_status_next = lbsa_pkg::STAT_FREE_IGNORED;
                    state_next      = S_DONE;
                end else begin
                    idx_next   = start_reg;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (mark_rdata_reg == lbsa_pkg::MARK_FREE) begin
                    res_status_next = lbsa_pkg::STAT_FREE_IGNORED;
                    state_next      = S_DONE;
                end else if (mark_rdata_reg == lbsa_pkg::MARK_LAST) begin
                    hi_next         = idx_reg;
                    fill_free_next  = 1'b1;
                    res_status_next = lbsa_pkg::STAT_FREED;
                    idx_next        = start_reg;
                    state_next      = S_FILL;
                end else if (idx_reg == LAST_IDX) begin
                    res_status_next = lbsa_pkg::STAT_FREE_IGNORED;
                    state_next      = S_DONE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (fill_free_reg) begin
                    mem_wdata = lbsa_pkg::MARK_FREE;
                end else if (idx_reg == hi_reg) begin
                    mem_wdata = lbsa_pkg::MARK_LAST;
                end else begin
                    mem_wdata = lbsa_pkg::MARK_USED;
                end
                if (idx_reg == hi_reg) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_address_next = res_address_reg;
                    m_status_next  = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mark_mem[idx_reg] <= mem_wdata;
        end
        mark_rdata_reg <= mark_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            base_reg    <= lbsa_pkg::BASE_UNSET;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            base_reg    <= base_next;
        end
        cand_reg          <= cand_next;
        start_reg         <= start_next;
        hi_reg            <= hi_next;
        phase_reg         <= phase_next;
        runlen_reg        <= runlen_next;
        need_reg          <= need_next;
        step_reg          <= step_next;
        fill_free_reg     <= fill_free_next;
        req_type_reg      <= req_type_next;
        byte_count_reg    <= byte_count_next;
        alignment_reg     <= alignment_next;
        block_address_reg <= block_address_next;
        res_address_reg   <= res_address_next;
        res_status_reg    <= res_status_next;
        m_address_reg     <= m_address_next;
        m_status_reg      <= m_status_next;
    end

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_scan_behind_cand, state_reg == S_SCAN, idx_reg >= cand_reg, "scan index fell below the candidate start line")
    `ASSERT_IMPLIES(a_fill_in_range, state_reg == S_FILL, idx_reg <= hi_reg, "fill pointer ran past the end of the block")
    `ASSERT_ALWAYS(a_free_addr_zero, !(m_valid && (m_status == lbsa_pkg::STAT_FREED || m_status == lbsa_pkg::STAT_FREE_IGNORED || m_status == lbsa_pkg::STAT_ALLOC_REFUSED)) || (m_address == 32'd0), "non-allocation result carries a non-zero address")

endmodule
